// ----- rtl/core/dlm_pkg.sv -----
package dlm_pkg;

  localparam int MAX_BOXES = 64;
  localparam int ADDR_W    = $clog2(MAX_BOXES);
  localparam int CNT_W     = $clog2(MAX_BOXES + 1);

  typedef logic [2:0] cfg_idx_t;

  localparam cfg_idx_t CFG_RULE_A_FROM  = 3'd0;
  localparam cfg_idx_t CFG_RULE_B_FROM  = 3'd1;
  localparam cfg_idx_t CFG_RULE_C_FROM  = 3'd2;
  localparam cfg_idx_t CFG_RULE_D_FROM  = 3'd3;
  localparam cfg_idx_t CFG_CAR_LABEL    = 3'd4;
  localparam cfg_idx_t CFG_BIKE_LABEL   = 3'd5;
  localparam cfg_idx_t CFG_PERSON_LABEL = 3'd6;

  localparam logic [7:0] RST_RULE_A_FROM  = 8'd6;
  localparam logic [7:0] RST_RULE_B_FROM  = 8'd7;
  localparam logic [7:0] RST_RULE_C_FROM  = 8'd28;
  localparam logic [7:0] RST_RULE_D_FROM  = 8'd3;
  localparam logic [7:0] RST_CAR_LABEL    = 8'd2;
  localparam logic [7:0] RST_BIKE_LABEL   = 8'd1;
  localparam logic [7:0] RST_PERSON_LABEL = 8'd0;

  typedef struct packed {
    logic [11:0] box_x;
    logic [11:0] box_y;
    logic [11:0] box_w;
    logic [11:0] box_h;
    logic [7:0]  box_label;
    logic        last_box;
  } in_box_t;

  typedef struct packed {
    logic [11:0] out_x;
    logic [11:0] out_y;
    logic [11:0] out_w;
    logic [11:0] out_h;
    logic [7:0]  out_label;
    logic        last_out;
    logic        none_left;
    logic        overflowed;
  } out_res_t;

  // one stored box plus its removal mark
  typedef struct packed {
    logic        rm;
    logic [7:0]  label;
    logic [11:0] h;
    logic [11:0] w;
    logic [11:0] y;
    logic [11:0] x;
  } box_entry_t;

endpackage

// ----- rtl/core/detection_label_merge.sv -----
// Detection label merge.
// Input channel (in_valid/in_stall/in_data): one detection box per request,
// one box a cycle while loading; last_box closes the frame. While a frame is
// processed in_stall stays high.
// Result channel (out_valid/out_stall/out_data): one request per surviving
// box in stored order, last_out on the final one; a frame with no survivor
// gives a single request with none_left set.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): cfg_ready is
// always high; indexes beyond the register list are ignored.
// Storage: all boxes live in one RAM with one read port and one write port
// and a registered read. Each of the four rules visits every stored box;
// each box of its source class is compared with every stored box (one RAM
// read per compared box and a three-stage overlap pipeline). The output
// pass then reads each stored box in turn and waits on receiver stalls.
// A stalled result holds in the output register; the output pass pauses
// until the register frees.
// Reset: returns to loading with an empty store and the register defaults.
module detection_label_merge (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dlm_pkg::in_box_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dlm_pkg::out_res_t  out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  dlm_pkg::cfg_idx_t  cfg_index,
  input  logic [7:0]         cfg_data
);
  import dlm_pkg::*;

  typedef enum logic [8:0] {
    S_LOAD     = 9'b000000001,
    S_RULE_RD  = 9'b000000010,
    S_RULE_CHK = 9'b000000100,
    S_SCAN     = 9'b000001000,
    S_WB       = 9'b000010000,
    S_OUT_RD   = 9'b000100000,
    S_OUT_EV   = 9'b001000000,
    S_OUT_END  = 9'b010000000,
    S_SPARE    = 9'b100000000
  } state_t;

  typedef enum logic [1:0] {
    RULE_A = 2'd0,
    RULE_B = 2'd1,
    RULE_C = 2'd2,
    RULE_D = 2'd3
  } rule_t;

  state_t          state_r;
  rule_t           rule_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] i_r;
  logic [CNT_W-1:0] n_r;
  logic            ovf_r;
  logic            found_r;

  logic [7:0] rule_a_from_r, rule_b_from_r, rule_c_from_r, rule_d_from_r;
  logic [7:0] car_label_r, bike_label_r, person_label_r;

  box_entry_t box_mem [MAX_BOXES];
  box_entry_t rd_q;
  logic       mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  box_entry_t mem_wdata;

  box_entry_t  cur_r;
  logic [23:0] st_r;
  logic        scan_rd_r;
  logic        s1_v_r, s1_ok_r;
  logic [12:0] s1_dx_r, s1_dy_r;
  logic        s2_v_r, s2_ok_r;
  logic [25:0] s2_so_r;

  box_entry_t  pend_r;
  logic        pend_v_r;
  logic        out_valid_r;
  out_res_t    out_data_r;

  logic       in_acc;
  logic       store_full;
  logic [7:0] from_lbl, target_lbl;
  logic       elig;
  logic       keep;
  logic       scan_done;
  logic       hit;
  logic       out_free;
  logic       out_push;
  out_res_t   out_push_data;

  logic [11:0] x1, y1;
  logic [12:0] ax2, bx2, ay2, by2, x2, y2;
  logic        ovx, ovy;
  logic [27:0] so3, st2;

  assign in_stall   = (state_r != S_LOAD);
  assign in_acc     = in_valid && !in_stall;
  assign cfg_ready  = 1'b1;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign store_full = (count_r == CNT_W'(MAX_BOXES));
  assign out_free   = !out_valid_r || !out_stall;

  always_comb begin
    case (rule_r)
      RULE_A:  from_lbl = rule_a_from_r;
      RULE_B:  from_lbl = rule_b_from_r;
      RULE_C:  from_lbl = rule_c_from_r;
      RULE_D:  from_lbl = rule_d_from_r;
      default: from_lbl = rule_a_from_r;
    endcase
    target_lbl = (rule_r == RULE_D) ? bike_label_r : car_label_r;
  end

  assign elig = !rd_q.rm && (rd_q.label == from_lbl);
  assign keep = !rd_q.rm && ((rd_q.label == car_label_r) ||
                (rd_q.label == bike_label_r) || (rd_q.label == person_label_r));

  // overlap geometry of the box just read against the box under test
  always_comb begin
    x1  = (cur_r.x > rd_q.x) ? cur_r.x : rd_q.x;
    y1  = (cur_r.y > rd_q.y) ? cur_r.y : rd_q.y;
    ax2 = {1'b0, cur_r.x} + {1'b0, cur_r.w};
    bx2 = {1'b0, rd_q.x} + {1'b0, rd_q.w};
    ay2 = {1'b0, cur_r.y} + {1'b0, cur_r.h};
    by2 = {1'b0, rd_q.y} + {1'b0, rd_q.h};
    x2  = (ax2 < bx2) ? ax2 : bx2;
    y2  = (ay2 < by2) ? ay2 : by2;
    ovx = x2 > {1'b0, x1};
    ovy = y2 > {1'b0, y1};
  end

  assign so3 = {2'b00, s2_so_r} + {1'b0, s2_so_r, 1'b0};
  assign st2 = {3'b000, st_r, 1'b0};
  assign hit = s2_v_r && s2_ok_r && (st2 < so3);
  assign scan_done = (n_r == count_r) && !scan_rd_r && !s1_v_r && !s2_v_r;

  // RAM port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count_r[ADDR_W-1:0];
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = i_r[ADDR_W-1:0];
    case (state_r)
      S_LOAD: begin
        mem_we    = in_acc && !store_full;
        mem_wdata = '{rm: 1'b0, label: in_data.box_label, h: in_data.box_h,
                      w: in_data.box_w, y: in_data.box_y, x: in_data.box_x};
      end
      S_RULE_RD: begin
        mem_re = (i_r != count_r);
      end
      S_RULE_CHK: begin
        mem_re    = elig;
        mem_raddr = '0;
      end
      S_SCAN: begin
        mem_re    = (n_r != count_r);
        mem_raddr = n_r[ADDR_W-1:0];
      end
      S_WB: begin
        mem_we    = 1'b1;
        mem_waddr = i_r[ADDR_W-1:0];
        mem_wdata = cur_r;
        if (found_r) begin
          mem_wdata.rm = 1'b1;
        end else begin
          mem_wdata.label = target_lbl;
        end
      end
      S_OUT_RD: begin
        mem_re = (i_r != count_r);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      box_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= box_mem[mem_raddr];
    end
  end

  // output register feed
  always_comb begin
    out_push      = 1'b0;
    out_push_data = '{out_x: pend_r.x, out_y: pend_r.y, out_w: pend_r.w,
                      out_h: pend_r.h, out_label: pend_r.label, last_out: 1'b0,
                      none_left: 1'b0, overflowed: ovf_r};
    case (state_r)
      S_OUT_EV: begin
        out_push = keep && pend_v_r && out_free;
      end
      S_OUT_END: begin
        out_push = out_free;
        out_push_data.last_out = 1'b1;
        if (!pend_v_r) begin
          out_push_data = '{out_x: '0, out_y: '0, out_w: '0, out_h: '0,
                            out_label: '0, last_out: 1'b1, none_left: 1'b1,
                            overflowed: ovf_r};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (out_push) begin
      out_data_r <= out_push_data;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_a_from_r  <= RST_RULE_A_FROM;
      rule_b_from_r  <= RST_RULE_B_FROM;
      rule_c_from_r  <= RST_RULE_C_FROM;
      rule_d_from_r  <= RST_RULE_D_FROM;
      car_label_r    <= RST_CAR_LABEL;
      bike_label_r   <= RST_BIKE_LABEL;
      person_label_r <= RST_PERSON_LABEL;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RULE_A_FROM:  rule_a_from_r  <= cfg_data;
        CFG_RULE_B_FROM:  rule_b_from_r  <= cfg_data;
        CFG_RULE_C_FROM:  rule_c_from_r  <= cfg_data;
        CFG_RULE_D_FROM:  rule_d_from_r  <= cfg_data;
        CFG_CAR_LABEL:    car_label_r    <= cfg_data;
        CFG_BIKE_LABEL:   bike_label_r   <= cfg_data;
        CFG_PERSON_LABEL: person_label_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // overlap pipeline: geometry, area, ratio test
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_rd_r <= 1'b0;
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
    end else begin
      scan_rd_r <= mem_re && ((state_r == S_SCAN) || (state_r == S_RULE_CHK));
      s1_v_r    <= scan_rd_r;
      s2_v_r    <= s1_v_r;
    end
    s1_ok_r <= !rd_q.rm && (rd_q.label == target_lbl) && ovx && ovy;
    s1_dx_r <= x2 - {1'b0, x1};
    s1_dy_r <= y2 - {1'b0, y1};
    s2_ok_r <= s1_ok_r;
    s2_so_r <= 26'(s1_dx_r) * 26'(s1_dy_r);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      rule_r   <= RULE_A;
      count_r  <= '0;
      i_r      <= '0;
      n_r      <= '0;
      ovf_r    <= 1'b0;
      found_r  <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            if (store_full) begin
              ovf_r <= 1'b1;
            end else begin
              count_r <= count_r + 1'b1;
            end
            if (in_data.last_box) begin
              i_r     <= '0;
              rule_r  <= RULE_A;
              state_r <= S_RULE_RD;
            end
          end
        end
        S_RULE_RD: begin
          if (i_r == count_r) begin
            i_r <= '0;
            if (rule_r == RULE_D) begin
              state_r <= S_OUT_RD;
            end else begin
              rule_r <= rule_t'(rule_r + 2'd1);
            end
          end else begin
            state_r <= S_RULE_CHK;
          end
        end
        S_RULE_CHK: begin
          if (elig) begin
            cur_r   <= rd_q;
            st_r    <= 24'(rd_q.w) * 24'(rd_q.h);
            n_r     <= CNT_W'(1);
            found_r <= 1'b0;
            state_r <= S_SCAN;
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= S_RULE_RD;
          end
        end
        S_SCAN: begin
          if (n_r != count_r) begin
            n_r <= n_r + 1'b1;
          end
          if (hit) begin
            found_r <= 1'b1;
          end
          if (scan_done) begin
            state_r <= S_WB;
          end
        end
        S_WB: begin
          i_r     <= i_r + 1'b1;
          state_r <= S_RULE_RD;
        end
        S_OUT_RD: begin
          state_r <= (i_r == count_r) ? S_OUT_END : S_OUT_EV;
        end
        S_OUT_EV: begin
          if (!keep) begin
            i_r     <= i_r + 1'b1;
            state_r <= S_OUT_RD;
          end else if (!pend_v_r || out_free) begin
            // hold one survivor back so the final one can carry last_out
            pend_r   <= rd_q;
            pend_v_r <= 1'b1;
            i_r      <= i_r + 1'b1;
            state_r  <= S_OUT_RD;
          end
        end
        S_OUT_END: begin
          if (out_free) begin
            pend_v_r <= 1'b0;
            count_r  <= '0;
            ovf_r    <= 1'b0;
            state_r  <= S_LOAD;
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_BOXES))
    else $error("box count beyond capacity");

  a_wb_drained: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WB |-> !scan_rd_r && !s1_v_r && !s2_v_r)
    else $error("write-back before overlap pipeline drained");

  a_none_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.none_left |-> out_data.last_out)
    else $error("none_left request without last_out");

  a_pend_empty_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOAD |-> !pend_v_r)
    else $error("pending survivor left over while loading");
`endif

endmodule

// ----- verif/testbench.sv -----
module testbench;
  import dlm_pkg::*;

  localparam int       SETTLE_CYCLES  = 20;
  localparam int       TIMEOUT_CYCLES = 1_000_000;
  localparam cfg_idx_t CFG_IDX_NONE   = 3'd7;

  typedef logic [7:0] label_set_t [7];

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  in_box_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_res_t out_data;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  cfg_idx_t cfg_index = CFG_RULE_A_FROM;
  logic [7:0] cfg_data = 8'd0;

  // label registers as the block should hold them
  logic [7:0] label_regs [7];
  label_set_t cur_set;
  bit         quiet = 1'b0;

  in_box_t  pending_boxes [$];
  in_box_t  frame_boxes   [$];
  bit       frame_overflow = 1'b0;
  out_res_t survivor_q    [$];
  int       errors = 0;
  int       in_gap = 0;
  int       stall_left = 0;

  always #5 clk = ~clk;

  detection_label_merge dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic longint unsigned overlap_area(in_box_t a, in_box_t b);
    int unsigned left, top, right, bottom, ar, br, ab, bb;
    left   = (a.box_x > b.box_x) ? 32'(a.box_x) : 32'(b.box_x);
    top    = (a.box_y > b.box_y) ? 32'(a.box_y) : 32'(b.box_y);
    ar     = int'(a.box_x) + int'(a.box_w);
    br     = int'(b.box_x) + int'(b.box_w);
    ab     = int'(a.box_y) + int'(a.box_h);
    bb     = int'(b.box_y) + int'(b.box_h);
    right  = (ar < br) ? ar : br;
    bottom = (ab < bb) ? ab : bb;
    if (right <= left || bottom <= top) return 0;
    return longint'(right - left) * longint'(bottom - top);
  endfunction

  // run the four relabel rules over the stored frame and queue the survivors
  function automatic void resolve_frame();
    logic [7:0]        lab  [MAX_BOXES];
    bit                gone [MAX_BOXES];
    logic [7:0]        from_lab, to_lab;
    longint unsigned   own, so;
    bit                hit;
    int                cnt, kept;
    out_res_t          r;
    cnt = frame_boxes.size();
    for (int i = 0; i < cnt; i++) begin
      lab[i]  = frame_boxes[i].box_label;
      gone[i] = 1'b0;
    end
    for (int k = CFG_RULE_A_FROM; k <= CFG_RULE_D_FROM; k++) begin
      from_lab = label_regs[k];
      to_lab   = (k == CFG_RULE_D_FROM) ? label_regs[CFG_BIKE_LABEL]
                                        : label_regs[CFG_CAR_LABEL];
      for (int i = 0; i < cnt; i++) begin
        if (gone[i] || lab[i] != from_lab) continue;
        own = longint'(frame_boxes[i].box_w) * longint'(frame_boxes[i].box_h);
        hit = 1'b0;
        for (int n = 0; n < cnt; n++) begin
          if (gone[n] || lab[n] != to_lab) continue;
          so = overlap_area(frame_boxes[n], frame_boxes[i]);
          if (so > 0 && 2 * own < 3 * so) hit = 1'b1;
        end
        if (hit) gone[i] = 1'b1;
        else lab[i] = to_lab;
      end
    end
    kept = 0;
    for (int i = 0; i < cnt; i++) begin
      if (gone[i]) continue;
      if (lab[i] != label_regs[CFG_CAR_LABEL] && lab[i] != label_regs[CFG_BIKE_LABEL] &&
          lab[i] != label_regs[CFG_PERSON_LABEL]) continue;
      r            = '0;
      r.out_x      = frame_boxes[i].box_x;
      r.out_y      = frame_boxes[i].box_y;
      r.out_w      = frame_boxes[i].box_w;
      r.out_h      = frame_boxes[i].box_h;
      r.out_label  = lab[i];
      r.overflowed = frame_overflow;
      survivor_q.push_back(r);
      kept++;
    end
    if (kept == 0) begin
      r            = '0;
      r.last_out   = 1'b1;
      r.none_left  = 1'b1;
      r.overflowed = frame_overflow;
      survivor_q.push_back(r);
    end else begin
      survivor_q[survivor_q.size() - 1].last_out = 1'b1;
    end
  endfunction

  function automatic void take_box(in_box_t b);
    if (frame_boxes.size() < MAX_BOXES) frame_boxes.push_back(b);
    else frame_overflow = 1'b1;
    if (b.last_box) begin
      resolve_frame();
      frame_boxes.delete();
      frame_overflow = 1'b0;
    end
  endfunction

  function automatic bit same_field(string name, int unsigned want, int unsigned got);
    if (want == got) return 1'b1;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    return 1'b0;
  endfunction

  function automatic void check_survivor(out_res_t want, out_res_t got);
    bit ok;
    ok = same_field("out_x", want.out_x, got.out_x);
    ok = same_field("out_y", want.out_y, got.out_y) && ok;
    ok = same_field("out_w", want.out_w, got.out_w) && ok;
    ok = same_field("out_h", want.out_h, got.out_h) && ok;
    ok = same_field("out_label", want.out_label, got.out_label) && ok;
    ok = same_field("last_out", want.last_out, got.last_out) && ok;
    ok = same_field("none_left", want.none_left, got.none_left) && ok;
    ok = same_field("overflowed", want.overflowed, got.overflowed) && ok;
    if (!ok) errors++;
  endfunction

  // box driver
  always @(posedge clk) begin : box_driver
    bit busy;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      in_gap   <= 0;
    end else begin
      busy = in_valid;
      if (in_valid && !in_stall) begin
        take_box(in_data);
        busy = 1'b0;
      end
      if (!busy) begin
        if (in_gap != 0) begin
          in_gap   <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_boxes.size() != 0) begin
          in_data  <= pending_boxes.pop_front();
          in_valid <= 1'b1;
          in_gap   <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (survivor_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
          errors++;
        end else begin
          check_survivor(survivor_q.pop_front(), out_data);
        end
      end
      if (stall_left != 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall  <= 1'b1;
        stall_left <= pick_gap();
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // track register writes
  always @(posedge clk) begin
    if (!rst_n) begin
      label_regs[CFG_RULE_A_FROM]  <= RST_RULE_A_FROM;
      label_regs[CFG_RULE_B_FROM]  <= RST_RULE_B_FROM;
      label_regs[CFG_RULE_C_FROM]  <= RST_RULE_C_FROM;
      label_regs[CFG_RULE_D_FROM]  <= RST_RULE_D_FROM;
      label_regs[CFG_CAR_LABEL]    <= RST_CAR_LABEL;
      label_regs[CFG_BIKE_LABEL]   <= RST_BIKE_LABEL;
      label_regs[CFG_PERSON_LABEL] <= RST_PERSON_LABEL;
    end else if (cfg_valid && cfg_ready && cfg_index <= CFG_PERSON_LABEL) begin
      label_regs[cfg_index] <= cfg_data;
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [7:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_regs(label_set_t set);
    cur_set = set;
    for (int i = CFG_RULE_A_FROM; i <= CFG_PERSON_LABEL; i++) write_reg(cfg_idx_t'(i), set[i]);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    while (pending_boxes.size() != 0 || in_valid || survivor_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic void queue_box(int x, int y, int w, int h, logic [7:0] lab, bit last);
    in_box_t b;
    b.box_x     = 12'(x);
    b.box_y     = 12'(y);
    b.box_w     = 12'(w);
    b.box_h     = 12'(h);
    b.box_label = lab;
    b.last_box  = last;
    pending_boxes.push_back(b);
  endfunction

  // mostly boxes packed into a small area with labels the rules act on
  function automatic void queue_frame(int n);
    int x, y, w, h;
    logic [7:0] lab;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 85) begin
        x = $urandom_range(0, 120);
        y = $urandom_range(0, 120);
        w = $urandom_range(0, 80);
        h = $urandom_range(0, 80);
      end else begin
        x = $urandom_range(0, 4095);
        y = $urandom_range(0, 4095);
        w = $urandom_range(0, 4095);
        h = $urandom_range(0, 4095);
      end
      if ($urandom_range(0, 99) < 80) lab = cur_set[$urandom_range(0, 6)];
      else lab = 8'($urandom_range(0, 255));
      queue_box(x, y, w, h, lab, i == n - 1);
    end
  endfunction

  initial begin : stimulus
    label_set_t defaults, set;
    int left, n;
    defaults = '{RST_RULE_A_FROM, RST_RULE_B_FROM, RST_RULE_C_FROM, RST_RULE_D_FROM,
                 RST_CAR_LABEL, RST_BIKE_LABEL, RST_PERSON_LABEL};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_regs(defaults);

    // nothing survives
    queue_box(10, 10, 10, 10, 8'hff, 1'b1);
    // field extremes
    queue_box(4095, 4095, 4095, 4095, RST_CAR_LABEL, 1'b0);
    queue_box(0, 0, 0, 0, RST_PERSON_LABEL, 1'b0);
    queue_box(4095, 0, 0, 4095, 8'hff, 1'b0);
    queue_box(0, 4095, 4095, 0, RST_BIKE_LABEL, 1'b1);
    // each rule: covered box removed, lone box relabeled, edge contact keeps
    queue_box(0, 0, 100, 100, RST_CAR_LABEL, 1'b0);
    queue_box(10, 10, 50, 50, RST_RULE_A_FROM, 1'b0);
    queue_box(500, 500, 20, 20, RST_RULE_B_FROM, 1'b0);
    queue_box(90, 90, 100, 100, RST_RULE_C_FROM, 1'b0);
    queue_box(100, 0, 50, 50, RST_RULE_A_FROM, 1'b0);
    queue_box(1000, 1000, 40, 40, RST_BIKE_LABEL, 1'b0);
    queue_box(1000, 1000, 40, 40, RST_RULE_D_FROM, 1'b0);
    queue_box(2000, 2000, 10, 10, RST_RULE_D_FROM, 1'b1);
    // ratio exactly at the limit keeps; a relabeled box then removes a later one
    queue_box(0, 0, 20, 10, RST_CAR_LABEL, 1'b0);
    queue_box(0, 0, 30, 10, RST_RULE_A_FROM, 1'b0);
    queue_box(0, 0, 30, 10, RST_RULE_B_FROM, 1'b0);
    queue_box(3000, 3000, 30, 10, RST_RULE_C_FROM, 1'b1);
    wait_idle();

    // source equal to target: a box with area removes itself, a flat one stays
    set = defaults;
    set[CFG_RULE_A_FROM] = RST_CAR_LABEL;
    write_regs(set);
    queue_box(5, 5, 10, 10, RST_CAR_LABEL, 1'b0);
    queue_box(0, 0, 0, 7, RST_CAR_LABEL, 1'b0);
    queue_box(7, 7, 3, 3, RST_RULE_B_FROM, 1'b1);
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set = defaults;
        1: set = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        2: set = '{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff};
        3: foreach (set[i]) set[i] = 8'($urandom_range(0, 7));
        4: set = '{8'hff, 8'h00, 8'h80, 8'h01, 8'h00, 8'hff, 8'h07};
        default: foreach (set[i]) set[i] = 8'($urandom_range(0, 255));
      endcase
      quiet = (ph == 2 || ph == 4);
      write_regs(set);
      if (ph == 1) begin
        write_reg(CFG_IDX_NONE, 8'h5a);
        @(negedge clk);
      end
      left = 25;
      while (left > 0) begin
        n = $urandom_range(1, 8);
        if (n > left) n = left;
        queue_frame(n);
        left -= n;
        // hold new boxes until the frame in flight has drained
        if ($urandom_range(0, 4) == 0) wait_idle();
      end
      if (ph == 0) begin
        queue_frame(MAX_BOXES);
        // full store; the dropped final box still ends the frame
        queue_frame(MAX_BOXES + 2);
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(10 * TIMEOUT_CYCLES);
    $display("Test completed with failures");
    $finish;
  end

endmodule
